@@ hw/rtl/lbg_pkg.sv @@
// ----------------------------------------------------------------------------
// lbg_pkg: shared types, constants and channel math for the LED blend block
// Holds the item and result payloads, the register map and the per-channel
// blend and gain functions.
// ----------------------------------------------------------------------------
package lbg_pkg;

	// Default number of LEDs held in the colour store
	localparam int LED_COUNT_DEF = 256;

	// Configuration port geometry
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 10;

	// Register indexes
	localparam logic [CFG_IW-1:0] REG_BLEND_WEIGHT    = 3'd0;
	localparam logic [CFG_IW-1:0] REG_RED_GAIN        = 3'd1;
	localparam logic [CFG_IW-1:0] REG_GREEN_GAIN      = 3'd2;
	localparam logic [CFG_IW-1:0] REG_BLUE_GAIN       = 3'd3;
	localparam logic [CFG_IW-1:0] REG_BLACK_THRESHOLD = 3'd4;

	// Item function codes
	localparam logic FUNC_UPDATE = 1'b0;
	localparam logic FUNC_LOAD   = 1'b1;

	// Full-scale blend weight (1.0) and unity gain
	localparam logic [8:0] BLEND_ONE = 9'd256;
	localparam logic [9:0] GAIN_ONE  = 10'd256;

	typedef struct packed {
		logic        func;
		logic [11:0] led_index;
		logic [7:0]  target_red;
		logic [7:0]  target_green;
		logic [7:0]  target_blue;
		logic [7:0]  gamma_slot;
		logic [7:0]  gamma_value;
	} item_t;

	typedef struct packed {
		logic [11:0] out_index;
		logic [7:0]  out_red;
		logic [7:0]  out_green;
		logic [7:0]  out_blue;
	} result_t;

	typedef struct packed {
		logic [8:0] blend_weight;
		logic [9:0] red_gain;
		logic [9:0] green_gain;
		logic [9:0] blue_gain;
		logic [7:0] black_threshold;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BLEND,
		ST_GAIN,
		ST_GAMMA
	} state_t;

	// Move one channel toward its target by w/256, rounding toward minus infinity
	function automatic logic [7:0] blend_chan(logic [7:0] cur, logic [7:0] tgt,
			logic [8:0] w);
		logic [7:0]  diff;
		logic [17:0] prod;
		logic [7:0]  step;
		logic [7:0]  res;
		if (tgt >= cur) begin
			diff = tgt - cur;
			prod = 18'(diff) * 18'(w);
			step = prod[15:8];
			res  = cur + step;
		end else begin
			diff = cur - tgt;
			prod = 18'(diff) * 18'(w) + 18'd255;
			step = prod[15:8];
			res  = cur - step;
		end
		return res;
	endfunction

	// Apply a Q2.8 gain and saturate to 8 bits
	function automatic logic [7:0] gain_chan(logic [7:0] b, logic [9:0] gain);
		logic [17:0] prod;
		logic [9:0]  hi;
		prod = 18'(b) * 18'(gain);
		hi   = prod[17:8];
		return (hi > 10'd255) ? 8'hFF : hi[7:0];
	endfunction

endpackage

@@ hw/rtl/lbg_stream_if.sv @@
// ----------------------------------------------------------------------------
// lbg_stream_if: valid/ready stream channel
// One beat moves when valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface lbg_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/lbg_ram.sv @@
// ----------------------------------------------------------------------------
// lbg_ram: generic single-write, single-read synchronous RAM
// Read data is registered and holds while no read is requested.
// ----------------------------------------------------------------------------
module lbg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/lbg_cfg.sv @@
// ----------------------------------------------------------------------------
// lbg_cfg: configuration register bank
// Decodes the write port into the blend, gain and threshold registers.
// ----------------------------------------------------------------------------
module lbg_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [lbg_pkg::CFG_IW-1:0] cfg_index,
	input  logic [lbg_pkg::CFG_DW-1:0] cfg_wdata,
	output lbg_pkg::cfg_t             cfg
);

	lbg_pkg::cfg_t cfg_q;

	// Take one register write per enabled edge; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blend_weight    <= lbg_pkg::BLEND_ONE;
			cfg_q.red_gain        <= lbg_pkg::GAIN_ONE;
			cfg_q.green_gain      <= lbg_pkg::GAIN_ONE;
			cfg_q.blue_gain       <= lbg_pkg::GAIN_ONE;
			cfg_q.black_threshold <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				lbg_pkg::REG_BLEND_WEIGHT:    cfg_q.blend_weight    <= cfg_wdata[8:0];
				lbg_pkg::REG_RED_GAIN:        cfg_q.red_gain        <= cfg_wdata[9:0];
				lbg_pkg::REG_GREEN_GAIN:      cfg_q.green_gain      <= cfg_wdata[9:0];
				lbg_pkg::REG_BLUE_GAIN:       cfg_q.blue_gain       <= cfg_wdata[9:0];
				lbg_pkg::REG_BLACK_THRESHOLD: cfg_q.black_threshold <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/lbg_engine.sv @@
// ----------------------------------------------------------------------------
// lbg_engine: colour store read-modify-write sequencer
// Reads the LED colour, blends toward the target, applies gain, looks up
// gamma, writes the result back and presents it through an output register.
// ----------------------------------------------------------------------------
module lbg_engine #(
	parameter int LED_COUNT = lbg_pkg::LED_COUNT_DEF,
	parameter int IW        = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lbg_pkg::cfg_t       cfg,
	lbg_stream_if.sink          items,
	lbg_stream_if.source        results
);

	lbg_pkg::state_t  state_q, state_d;
	logic [IW-1:0]    clr_q;
	logic             clr_last;
	logic             acc;
	logic             in_range;
	logic             upd_go;
	logic             load_go;
	logic             fin;
	logic [11:0]      idx_s1;
	logic [7:0]       tr_s1, tg_s1, tb_s1;
	logic [7:0]       br_s2, bg_s2, bb_s2;
	logic [8:0]       w_eff;
	logic [23:0]      cur;
	logic [7:0]       gr, gg, gb;
	logic [7:0]       gam_r, gam_g, gam_b;
	logic [7:0]       or_c, og_c, ob_c;
	logic             col_we;
	logic [IW-1:0]    col_waddr;
	logic [23:0]      col_wdata;
	logic             out_valid_q;
	lbg_pkg::result_t out_q;

	// Input handshake and item decode
	assign items.ready = (state_q == lbg_pkg::ST_IDLE);
	assign acc         = items.valid && items.ready;
	assign in_range    = {1'b0, items.data.led_index} < 13'(LED_COUNT);
	assign upd_go      = acc && (items.data.func == lbg_pkg::FUNC_UPDATE) && in_range;
	assign load_go     = acc && (items.data.func == lbg_pkg::FUNC_LOAD);
	assign clr_last    = (clr_q == IW'(LED_COUNT - 1));
	assign fin         = (state_q == lbg_pkg::ST_GAMMA) && (!out_valid_q || results.ready);

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbg_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lbg_pkg::ST_CLEAR: if (clr_last) state_d = lbg_pkg::ST_IDLE;
			lbg_pkg::ST_IDLE:  if (upd_go) state_d = lbg_pkg::ST_BLEND;
			lbg_pkg::ST_BLEND: state_d = lbg_pkg::ST_GAIN;
			lbg_pkg::ST_GAIN:  state_d = lbg_pkg::ST_GAMMA;
			lbg_pkg::ST_GAMMA: if (fin) state_d = lbg_pkg::ST_IDLE;
			default:           state_d = lbg_pkg::ST_IDLE;
		endcase
	end

	// Advance the clearing pointer through the colour store after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == lbg_pkg::ST_CLEAR && !clr_last) begin
			clr_q <= clr_q + IW'(1);
		end
	end

	// Capture the accepted update
	always_ff @(posedge clk) begin
		if (upd_go) begin
			idx_s1 <= items.data.led_index;
			tr_s1  <= items.data.target_red;
			tg_s1  <= items.data.target_green;
			tb_s1  <= items.data.target_blue;
		end
	end

	// Blend stage: stored colour toward target
	assign w_eff = cfg.blend_weight[8] ? lbg_pkg::BLEND_ONE : cfg.blend_weight;

	always_ff @(posedge clk) begin
		if (state_q == lbg_pkg::ST_BLEND) begin
			br_s2 <= lbg_pkg::blend_chan(cur[23:16], tr_s1, w_eff);
			bg_s2 <= lbg_pkg::blend_chan(cur[15:8], tg_s1, w_eff);
			bb_s2 <= lbg_pkg::blend_chan(cur[7:0], tb_s1, w_eff);
		end
	end

	// Gain stage feeds the gamma lookup addresses
	assign gr = lbg_pkg::gain_chan(br_s2, cfg.red_gain);
	assign gg = lbg_pkg::gain_chan(bg_s2, cfg.green_gain);
	assign gb = lbg_pkg::gain_chan(bb_s2, cfg.blue_gain);

	// Black threshold on the gamma outputs
	assign or_c = (gam_r < cfg.black_threshold) ? 8'd0 : gam_r;
	assign og_c = (gam_g < cfg.black_threshold) ? 8'd0 : gam_g;
	assign ob_c = (gam_b < cfg.black_threshold) ? 8'd0 : gam_b;

	// Colour store write: clearing pass or write-back
	assign col_we    = (state_q == lbg_pkg::ST_CLEAR) || fin;
	assign col_waddr = (state_q == lbg_pkg::ST_CLEAR) ? clr_q : idx_s1[IW-1:0];
	assign col_wdata = (state_q == lbg_pkg::ST_CLEAR) ? 24'd0 : {or_c, og_c, ob_c};

	lbg_ram #(.WIDTH(24), .DEPTH(LED_COUNT)) u_colour (
		.clk   (clk),
		.we    (col_we),
		.waddr (col_waddr),
		.wdata (col_wdata),
		.re    (upd_go),
		.raddr (items.data.led_index[IW-1:0]),
		.rdata (cur)
	);

	// One gamma copy per channel, all loaded together
	lbg_ram #(.WIDTH(8), .DEPTH(256)) u_gamma_r (
		.clk   (clk),
		.we    (load_go),
		.waddr (items.data.gamma_slot),
		.wdata (items.data.gamma_value),
		.re    (state_q == lbg_pkg::ST_GAIN),
		.raddr (gr),
		.rdata (gam_r)
	);

	lbg_ram #(.WIDTH(8), .DEPTH(256)) u_gamma_g (
		.clk   (clk),
		.we    (load_go),
		.waddr (items.data.gamma_slot),
		.wdata (items.data.gamma_value),
		.re    (state_q == lbg_pkg::ST_GAIN),
		.raddr (gg),
		.rdata (gam_g)
	);

	lbg_ram #(.WIDTH(8), .DEPTH(256)) u_gamma_b (
		.clk   (clk),
		.we    (load_go),
		.waddr (items.data.gamma_slot),
		.wdata (items.data.gamma_value),
		.re    (state_q == lbg_pkg::ST_GAIN),
		.raddr (gb),
		.rdata (gam_b)
	);

	// Output register: load on finish, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			out_q.out_index <= idx_s1;
			out_q.out_red   <= or_c;
			out_q.out_green <= og_c;
			out_q.out_blue  <= ob_c;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_q;

`ifndef NO_ASSERTIONS
	a_update_starts: assert property (@(posedge clk) disable iff (!arst_n)
		upd_go |=> state_q == lbg_pkg::ST_BLEND)
		else $error("update beat did not start the blend stage");

	a_blend_to_gain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lbg_pkg::ST_BLEND |=> state_q == lbg_pkg::ST_GAIN)
		else $error("blend stage did not advance to gain");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lbg_pkg::ST_GAMMA && out_valid_q && !results.ready
		|=> state_q == lbg_pkg::ST_GAMMA)
		else $error("write-back left while the output register was full");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == lbg_pkg::ST_GAMMA)
		else $error("result appeared without a finished update");
`endif

endmodule

@@ hw/rtl/led_blend_gain_gamma_top.sv @@
// ----------------------------------------------------------------------------
// led_blend_gain_gamma_top: per-LED colour smoothing with gain and gamma
// Top level: configuration registers and the colour store engine.
// ----------------------------------------------------------------------------
// After reset the block sweeps the colour store to zero, one LED per cycle,
// and takes no items until the sweep ends (register writes are taken
// throughout). An update item occupies the engine through the colour store
// read, the blend stage, the gain stage with the gamma lookup, and the
// write-back into the output register; the next item is taken in the cycle
// after that, so the engine takes no new update before the last one is
// written back, as the read-modify-write of the colour store must finish
// before the next update reads it. A finished result waits in the output
// register and stalls the write-back only when a second result is ready
// before the first is taken. A gamma load item and an update with an
// out-of-range index are taken in the idle state and give no result.
module led_blend_gain_gamma_top #(
	parameter int LED_COUNT = lbg_pkg::LED_COUNT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [lbg_pkg::CFG_IW-1:0] cfg_index,
	input  logic [lbg_pkg::CFG_DW-1:0] cfg_wdata,
	lbg_stream_if.sink                items,
	lbg_stream_if.source              results
);

	lbg_pkg::cfg_t cfg;

	// Register bank
	lbg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Colour store engine
	lbg_engine #(.LED_COUNT(LED_COUNT)) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.items   (items),
		.results (results)
	);

endmodule
